[rtl/psa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and codes of the pool slot allocator: operation and status
// codes, register map and the command/status bundles between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package psa_pkg;

    localparam int ADDR_W     = 16;
    localparam int COUNT_W    = 16;
    localparam int OBJ_SIZE_W = 12;
    localparam int EPB_W      = 9;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    // Operation codes
    localparam logic [1:0] FN_ALLOC    = 2'd0;
    localparam logic [1:0] FN_RECYCLE  = 2'd1;
    localparam logic [1:0] FN_ROLLBACK = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [1:0] ST_DROPPED   = 2'd2;
    localparam logic [1:0] ST_NULL      = 2'd3;

    // Register index, taken from paddr[2]
    localparam logic REG_OBJ_SIZE = 1'b0;
    localparam logic REG_EPB      = 1'b1;

    localparam logic [OBJ_SIZE_W-1:0] OBJ_SIZE_RST = 12'd8;
    localparam logic [OBJ_SIZE_W-1:0] MIN_OBJ_SIZE = 12'd8;
    localparam logic [EPB_W-1:0]      EPB_RST      = 9'd508;

    // Result select codes
    localparam logic [2:0] RES_NONE      = 3'd0;
    localparam logic [2:0] RES_OK        = 3'd1;
    localparam logic [2:0] RES_EXHAUSTED = 3'd2;
    localparam logic [2:0] RES_DROPPED   = 3'd3;
    localparam logic [2:0] RES_NULL      = 3'd4;
    localparam logic [2:0] RES_POP       = 3'd5;
    localparam logic [2:0] RES_BUMP      = 3'd6;

    typedef struct packed {
        logic       load_in;
        logic       pop_read;
        logic       push;
        logic       advance;
        logic       bump_mul;
        logic       roll_step;
        logic       load_out;
        logic [2:0] res_sel;
    } psa_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       stack_empty;
        logic       stack_full;
        logic       addr_null;
        logic       epb_zero;
        logic       entry_full;
        logic       last_block;
        logic       roll_done;
        logic       out_free;
    } psa_sts_t;

endpackage

[rtl/psa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_ctrl
// Sequencer of the pool slot allocator: takes one item at a time and steps
// the datapath through pop, bump, recycle or rollback.
// ----------------------------------------------------------------------------
module psa_ctrl
    import psa_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  psa_sts_t sts,
    output psa_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_POP  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;
    localparam logic [2:0] S_ROLL = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = RES_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (sts.func)
                    FN_ALLOC:
                    begin
                        if (!sts.stack_empty)
                        begin
                            cmd.pop_read = 1'b1;
                            state_next   = S_POP;
                        end
                        else if (sts.epb_zero)
                        begin
                            cmd.res_sel = RES_EXHAUSTED;
                        end
                        else if (sts.entry_full)
                        begin
                            if (sts.last_block)
                            begin
                                cmd.res_sel = RES_EXHAUSTED;
                            end
                            else
                            begin
                                cmd.advance = 1'b1;
                                state_next  = S_MUL;
                            end
                        end
                        else
                        begin
                            state_next = S_MUL;
                        end
                    end
                    FN_RECYCLE:
                    begin
                        if (sts.addr_null)
                        begin
                            cmd.res_sel = RES_NULL;
                        end
                        else if (sts.stack_full)
                        begin
                            cmd.res_sel = RES_DROPPED;
                        end
                        else
                        begin
                            cmd.push    = 1'b1;
                            cmd.res_sel = RES_OK;
                        end
                    end
                    FN_ROLLBACK:
                    begin
                        state_next = S_ROLL;
                    end
                    default:
                    begin
                        cmd.res_sel = RES_OK;
                    end
                endcase
            end
            S_POP:
            begin
                cmd.res_sel = RES_POP;
                state_next  = S_DONE;
            end
            S_MUL:
            begin
                cmd.bump_mul = 1'b1;
                state_next   = S_SUM;
            end
            S_SUM:
            begin
                cmd.res_sel = RES_BUMP;
                state_next  = S_DONE;
            end
            S_ROLL:
            begin
                if (sts.roll_done)
                begin
                    cmd.res_sel = RES_OK;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.roll_step = 1'b1;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/psa_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_dp
// Datapath of the pool slot allocator: configuration registers, free stack
// memory, bump pointer, address multiplier, rollback walker, output register.
// ----------------------------------------------------------------------------
module psa_dp
    import psa_pkg::*;
#(
    parameter int BLOCK_BYTES  = 4096,
    parameter int HEADER_BYTES = 32,
    parameter int MAX_BLOCKS   = 16,
    parameter int FREE_DEPTH   = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  psa_cmd_t              cmd,
    output psa_sts_t              sts,
    input  logic [1:0]            func,
    input  logic [ADDR_W-1:0]     free_address,
    input  logic [COUNT_W-1:0]    rollback_count,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic [ADDR_W-1:0]     object_address,
    output logic [1:0]            status,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [PDATA_W-1:0]    cfg_wdata,
    output logic [PDATA_W-1:0]    cfg_rdata
);

    localparam int BW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int AW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
    localparam int CW = $clog2(FREE_DEPTH + 1);
    localparam logic [ADDR_W-1:0] BLOCK_LO   = ADDR_W'(BLOCK_BYTES % 65536);
    localparam logic [ADDR_W-1:0] HEADER_LO  = ADDR_W'(HEADER_BYTES);
    localparam logic [BW-1:0]     LAST_BLOCK = BW'(MAX_BLOCKS - 1);
    localparam logic [CW-1:0]     STACK_CAP  = CW'(FREE_DEPTH);

    // Configuration
    logic [OBJ_SIZE_W-1:0] obj_size_reg, obj_size_next;
    logic [EPB_W-1:0]      epb_reg, epb_next;

    // Allocator state
    logic [CW-1:0]         count_reg, count_next;
    logic [BW-1:0]         block_reg, block_next;
    logic [EPB_W-1:0]      entry_reg, entry_next;

    // Item and working registers
    logic [1:0]            func_reg, func_next;
    logic [ADDR_W-1:0]     faddr_reg, faddr_next;
    logic [COUNT_W-1:0]    roll_reg, roll_next;
    logic [ADDR_W-1:0]     base_reg, base_next;
    logic [ADDR_W-1:0]     prod_reg, prod_next;
    logic [ADDR_W-1:0]     res_addr_reg, res_addr_next;
    logic [1:0]            res_status_reg, res_status_next;
    logic [ADDR_W-1:0]     out_addr_reg, out_addr_next;
    logic [1:0]            out_status_reg, out_status_next;
    logic                  out_valid_reg, out_valid_next;

    // Free stack
    logic [ADDR_W-1:0]     stack_mem_reg [FREE_DEPTH];
    logic [ADDR_W-1:0]     rd_data_reg;
    logic [CW-1:0]         count_dec;
    logic [AW-1:0]         wr_idx;
    logic [AW-1:0]         rd_idx;

    logic [OBJ_SIZE_W-1:0] eff_size;
    logic [ADDR_W-1:0]     entry_wide;

    assign count_dec  = count_reg - 1'b1;
    assign wr_idx     = count_reg[AW-1:0];
    assign rd_idx     = count_dec[AW-1:0];
    assign eff_size   = (obj_size_reg < MIN_OBJ_SIZE) ? MIN_OBJ_SIZE : obj_size_reg;
    assign entry_wide = ADDR_W'(entry_reg);

    assign sts.func        = func_reg;
    assign sts.stack_empty = (count_reg == '0);
    assign sts.stack_full  = (count_reg == STACK_CAP);
    assign sts.addr_null   = (faddr_reg == '0);
    assign sts.epb_zero    = (epb_reg == '0);
    assign sts.entry_full  = (entry_reg >= epb_reg);
    assign sts.last_block  = (block_reg == LAST_BLOCK);
    assign sts.roll_done   = (roll_reg == '0);
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign out_valid      = out_valid_reg;
    assign object_address = out_addr_reg;
    assign status         = out_status_reg;
    assign cfg_rdata      = (cfg_index == REG_EPB) ? PDATA_W'(epb_reg) : PDATA_W'(obj_size_reg);

    always_comb
    begin
        obj_size_next   = obj_size_reg;
        epb_next        = epb_reg;
        count_next      = count_reg;
        block_next      = block_reg;
        entry_next      = entry_reg;
        func_next       = func_reg;
        faddr_next      = faddr_reg;
        roll_next       = roll_reg;
        base_next       = base_reg;
        prod_next       = prod_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && out_stall;

        if (cfg_write)
        begin
            if (cfg_index == REG_OBJ_SIZE)
            begin
                obj_size_next = cfg_wdata[OBJ_SIZE_W-1:0];
            end
            else
            begin
                epb_next = cfg_wdata[EPB_W-1:0];
            end
        end

        if (cmd.load_in)
        begin
            func_next  = func;
            faddr_next = free_address;
            roll_next  = rollback_count;
        end

        if (cmd.push)
        begin
            count_next = count_reg + 1'b1;
        end
        if (cmd.pop_read)
        begin
            count_next = count_dec;
        end

        // Open the next block
        if (cmd.advance)
        begin
            block_next = block_reg + 1'b1;
            entry_next = '0;
        end

        if (cmd.bump_mul)
        begin
            base_next = ADDR_W'(block_reg) * BLOCK_LO + HEADER_LO;
            prod_next = ADDR_W'(entry_reg) * ADDR_W'(eff_size);
        end

        // One step of the rollback walk; clear the count to stop
        if (cmd.roll_step)
        begin
            if (roll_reg > entry_wide)
            begin
                roll_next  = roll_reg - entry_wide;
                entry_next = '0;
                if (block_reg != '0)
                begin
                    block_next = block_reg - 1'b1;
                    entry_next = epb_reg;
                end
                else
                begin
                    roll_next = '0;
                end
            end
            else
            begin
                entry_next = entry_reg - roll_reg[EPB_W-1:0];
                roll_next  = '0;
            end
        end

        case (cmd.res_sel)
            RES_NONE:
            begin
                res_addr_next = res_addr_reg;
            end
            RES_OK:
            begin
                res_addr_next   = '0;
                res_status_next = ST_OK;
            end
            RES_EXHAUSTED:
            begin
                res_addr_next   = '0;
                res_status_next = ST_EXHAUSTED;
            end
            RES_DROPPED:
            begin
                res_addr_next   = '0;
                res_status_next = ST_DROPPED;
            end
            RES_NULL:
            begin
                res_addr_next   = '0;
                res_status_next = ST_NULL;
            end
            RES_POP:
            begin
                res_addr_next   = rd_data_reg;
                res_status_next = ST_OK;
            end
            RES_BUMP:
            begin
                res_addr_next   = base_reg + prod_reg;
                res_status_next = ST_OK;
                entry_next      = entry_reg + 1'b1;
            end
            default:
            begin
                res_addr_next = res_addr_reg;
            end
        endcase

        if (cmd.load_out)
        begin
            out_addr_next   = res_addr_reg;
            out_status_next = res_status_reg;
            out_valid_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obj_size_reg  <= OBJ_SIZE_RST;
            epb_reg       <= EPB_RST;
            count_reg     <= '0;
            block_reg     <= '0;
            entry_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            obj_size_reg  <= obj_size_next;
            epb_reg       <= epb_next;
            count_reg     <= count_next;
            block_reg     <= block_next;
            entry_reg     <= entry_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        faddr_reg      <= faddr_next;
        roll_reg       <= roll_next;
        base_reg       <= base_next;
        prod_reg       <= prod_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    // Free stack memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stack_mem_reg[wr_idx] <= faddr_reg;
        end
        if (cmd.pop_read)
        begin
            rd_data_reg <= stack_mem_reg[rd_idx];
        end
    end

endmodule

[rtl/pool_slot_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_slot_allocator
// Fixed-size object pool: LIFO free stack of recycled addresses in front of a
// block-by-block bump allocator, with rollback of bump allocations.
// ----------------------------------------------------------------------------
// The block takes one item at a time. From the accept of an item, an
// allocate served from the free stack steps through EXEC, POP (one memory
// read) and DONE; a bump allocate through EXEC, MUL (the entry-times-size
// multiply), SUM (the final add) and DONE; an allocate that reports
// exhaustion, a recycle or an unused func code through EXEC and DONE; and
// a rollback through EXEC, ROLL and DONE, staying in ROLL for each step of
// its walk, where one step retires the count inside one block; the walk
// takes at most MAX_BLOCKS steps. Results wait in an output register, so
// the next item is accepted while a result is still stalled; an item is
// only held back in DONE if the previous result is still not taken. The
// free stack starts empty and needs no clearing pass.
// Configuration (the object size in bytes at byte 0, the number of entries
// in a block at byte 4) is written through the APB-style port; the user must
// write it only while no item is in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
module pool_slot_allocator
    import psa_pkg::*;
#(
    parameter int BLOCK_BYTES  = 4096,
    parameter int HEADER_BYTES = 32,
    parameter int MAX_BLOCKS   = 16,
    parameter int FREE_DEPTH   = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    // Item channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [ADDR_W-1:0]  free_address,
    input  logic [COUNT_W-1:0] rollback_count,
    // Result channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [ADDR_W-1:0]  object_address,
    output logic [1:0]         status,
    // Configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    psa_cmd_t cmd;
    psa_sts_t sts;
    logic     cfg_write;

    // Zero-wait-state port; the register is picked by the word address bit
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    psa_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    psa_dp
    #(
        .BLOCK_BYTES  (BLOCK_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_BLOCKS   (MAX_BLOCKS),
        .FREE_DEPTH   (FREE_DEPTH)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .func           (func),
        .free_address   (free_address),
        .rollback_count (rollback_count),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .object_address (object_address),
        .status         (status),
        .cfg_write      (cfg_write),
        .cfg_index      (paddr[2]),
        .cfg_wdata      (pwdata),
        .cfg_rdata      (prdata)
    );

endmodule

[rtl/psa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_checker
// Port-level checks of the pool slot allocator, bound to the top level.
// ----------------------------------------------------------------------------
module psa_checker
    import psa_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [ADDR_W-1:0]  object_address,
    input logic [1:0]         status,
    input logic               pready
);

    // A stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(object_address) && $stable(status))
        else $error("stalled result changed");

    // One item at a time: the cycle after an accept takes no item
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while another is in flight");

    // No result appears the cycle right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result too early");

    // Any non-ok status carries a null address
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (object_address == '0) && pready)
        else $error("non-ok result with an address");

endmodule

bind pool_slot_allocator psa_checker u_psa_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .object_address (object_address),
    .status         (status),
    .pready         (pready)
);
